>>> design/x86_64_instruction_encoder_unit_macros.svh
// Assertion macros shared by the encoder unit's RTL files.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef X86_64_INSTRUCTION_ENCODER_UNIT_MACROS_SVH
`define X86_64_INSTRUCTION_ENCODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ENC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ENC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/x86enc_pkg.sv
// Package for the x86-64 instruction encoder unit: payload types and codes.
// It has no dependencies; the encoder and the top level import it.
`timescale 1ns / 1ps

package x86enc_pkg;

   localparam logic [2:0] MODE_PUSH  = 3'd0;
   localparam logic [2:0] MODE_POP   = 3'd1;
   localparam logic [2:0] MODE_MOV   = 3'd2;
   localparam logic [2:0] MODE_CALL  = 3'd3;
   localparam logic [2:0] MODE_LEAVE = 3'd4;
   localparam logic [2:0] MODE_RET   = 3'd5;

   localparam logic [1:0] KIND_REG = 2'd0;
   localparam logic [1:0] KIND_MEM = 2'd1;
   localparam logic [1:0] KIND_SYM = 2'd2;
   localparam logic [1:0] KIND_IMM = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_COUNT = 2'd1;
   localparam logic [1:0] ERR_TYPES = 2'd2;
   localparam logic [1:0] ERR_BASE  = 2'd3;

   localparam logic [7:0] OP_PUSH    = 8'h50;
   localparam logic [7:0] OP_POP     = 8'h58;
   localparam logic [7:0] OP_MOV_IMM = 8'hc7;
   localparam logic [7:0] OP_MOV_LD  = 8'h8b;
   localparam logic [7:0] OP_MOV_ST  = 8'h89;
   localparam logic [7:0] OP_CALL    = 8'he8;
   localparam logic [7:0] OP_LEAVE   = 8'hc9;
   localparam logic [7:0] OP_RET     = 8'hc3;
   localparam logic [7:0] REX_W      = 8'h48;
   localparam logic [7:0] REX_BASE   = 8'h40;

   localparam int unsigned MAX_BYTES = 7;
   localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

   typedef struct packed {
      logic [2:0]         mode;
      logic [1:0]         operand_count;
      logic [1:0]         first_kind;
      logic [3:0]         first_reg;
      logic signed [31:0] first_disp;
      logic signed [31:0] first_imm;
      logic [1:0]         second_kind;
      logic [3:0]         second_reg;
      logic signed [31:0] second_disp;
   } req_type;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic [31:0] byte_offset;
      logic        is_last;
      logic        reloc_here;
      logic [1:0]  error_code;
   } rsp_type;

   // One encoded instruction: its bytes, how many there are, and its status.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
      logic                      is_call;
      logic [1:0]                err;
   } enc_type;

endpackage

>>> design/x86_64_instruction_encoder_unit.sv
// x86-64 instruction encoder unit: a request is registered, encoded, and its bytes leave
// one per cycle unless rsp_stall holds them. Request register, combinational encoder, then
// output register; an instruction of n bytes (1 to 7, or one error result) holds the byte
// serialiser until its last byte leaves, so one-byte instructions stream back to back.
// Synchronous active-high reset clears the valid flags, byte index and text offset.
`timescale 1ns / 1ps

`include "x86_64_instruction_encoder_unit_macros.svh"

module x86_64_instruction_encoder_unit
   import x86enc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic             in_valid_ff, in_valid_in;
   req_type          req_ff;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [31:0]      text_offset_ff, text_offset_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   enc_type          enc;
   logic             out_load;
   logic             last_byte;
   logic             in_done;
   logic             req_take;

   x86enc_encode u_encode (
      .clock (clock),
      .reset (reset),
      .valid (in_valid_ff),
      .req   (req_ff),
      .enc   (enc)
   );

   assign out_load  = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign last_byte = (idx_ff == enc.count - CNT_W'(1));
   assign in_done   = out_load && last_byte;
   // The held request frees up in the cycle its last byte moves to the output.
   assign req_stall = in_valid_ff && !in_done;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in    = req_take || (in_valid_ff && !in_done);
   assign idx_in         = out_load ? (last_byte ? '0 : idx_ff + CNT_W'(1)) : idx_ff;
   assign rsp_valid_in   = out_load || (rsp_valid_ff && rsp_stall);
   assign text_offset_in = text_offset_ff + {31'd0, out_load && enc.err == ERR_NONE};

   always_comb begin
      rsp_in.code_byte   = enc.bytes[idx_ff[2:0]];
      rsp_in.byte_offset = text_offset_ff;
      rsp_in.is_last     = last_byte;
      rsp_in.reloc_here  = enc.is_call && (idx_ff == CNT_W'(1));
      rsp_in.error_code  = enc.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         idx_ff         <= '0;
         text_offset_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         idx_ff         <= idx_in;
         text_offset_ff <= text_offset_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ENC_ASSERT_SAME(a_idx_in_range, in_valid_ff, idx_ff < enc.count, "byte index beyond encoded length")
   `ENC_ASSERT_NEXT(a_offset_hold, !(out_load && enc.err == ERR_NONE), $stable(text_offset_ff), "text offset moved without an emitted byte")
   `ENC_ASSERT_SAME(a_err_last, rsp_valid_ff && rsp_ff.error_code != ERR_NONE, rsp_ff.is_last && rsp_ff.code_byte == 8'd0, "error result must be a single zero byte")
   `ENC_ASSERT_SAME(a_reloc_shape, rsp_valid_ff && rsp_ff.reloc_here, !rsp_ff.is_last && rsp_ff.code_byte == 8'd0, "relocation flag on a wrong byte")

endmodule

>>> design/x86enc_encode.sv
// Combinational encoder: turns one registered request into its byte string.
// Depends on x86enc_pkg for the payload types, opcodes and error codes.
`timescale 1ns / 1ps

`include "x86_64_instruction_encoder_unit_macros.svh"

module x86enc_encode
   import x86enc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    valid,
   input  req_type req,
   output enc_type enc
);

   logic        bad_first;
   logic        bad_second;
   logic        store_form;
   logic [7:0]  mem_opc;
   logic [3:0]  mem_regf;
   logic [3:0]  mem_base;
   logic [31:0] mem_disp;
   logic [1:0]  mem_mod;
   logic        disp_short;

   // Bases whose low three bits are 4 or 5 would need SIB or RIP-relative forms.
   assign bad_first  = (req.first_reg[2:0] == 3'd4) || (req.first_reg[2:0] == 3'd5);
   assign bad_second = (req.second_reg[2:0] == 3'd4) || (req.second_reg[2:0] == 3'd5);

   assign store_form = (req.first_kind == KIND_REG) && (req.second_kind == KIND_MEM);
   assign mem_opc    = store_form ? OP_MOV_ST : OP_MOV_LD;
   assign mem_regf   = store_form ? req.first_reg : req.second_reg;
   assign mem_base   = store_form ? req.second_reg : req.first_reg;
   assign mem_disp   = store_form ? req.second_disp : req.first_disp;

   // A displacement fits in eight bits when its top 25 bits are all equal.
   assign disp_short = (mem_disp[31:7] == '0) || (mem_disp[31:7] == '1);
   assign mem_mod    = (mem_disp == '0) ? 2'd0 : (disp_short ? 2'd1 : 2'd2);

   always_comb begin
      enc       = '0;
      enc.count = CNT_W'(1);
      enc.err   = ERR_NONE;
      unique case (req.mode) inside
         MODE_PUSH, MODE_POP: begin
            if (req.operand_count != 2'd1) begin
               enc.err = ERR_COUNT;
            end else if (req.first_kind != KIND_REG) begin
               enc.err = ERR_TYPES;
            end else if (req.first_reg[3]) begin
               enc.bytes[0] = REX_BASE | 8'h01;
               enc.bytes[1] = ((req.mode == MODE_PUSH) ? OP_PUSH : OP_POP)
                              | {5'd0, req.first_reg[2:0]};
               enc.count    = CNT_W'(2);
            end else begin
               enc.bytes[0] = ((req.mode == MODE_PUSH) ? OP_PUSH : OP_POP)
                              | {5'd0, req.first_reg[2:0]};
            end
         end
         MODE_MOV: begin
            if (req.operand_count != 2'd2) begin
               enc.err = ERR_COUNT;
            end else if (req.first_kind == KIND_IMM && req.second_kind == KIND_REG) begin
               enc.bytes[0] = REX_W | {7'd0, req.second_reg[3]};
               enc.bytes[1] = OP_MOV_IMM;
               enc.bytes[2] = {5'b11000, req.second_reg[2:0]};
               enc.bytes[3] = req.first_imm[7:0];
               enc.bytes[4] = req.first_imm[15:8];
               enc.bytes[5] = req.first_imm[23:16];
               enc.bytes[6] = req.first_imm[31:24];
               enc.count    = CNT_W'(7);
            end else if (req.first_kind == KIND_REG && req.second_kind == KIND_REG) begin
               enc.bytes[0] = REX_W | {5'd0, req.second_reg[3], 1'b0, req.first_reg[3]};
               enc.bytes[1] = OP_MOV_LD;
               enc.bytes[2] = {2'b11, req.second_reg[2:0], req.first_reg[2:0]};
               enc.count    = CNT_W'(3);
            end else if (store_form || (req.first_kind == KIND_MEM &&
                                        req.second_kind == KIND_REG)) begin
               if (store_form ? bad_second : bad_first) begin
                  enc.err = ERR_BASE;
               end else begin
                  enc.bytes[0] = REX_W | {5'd0, mem_regf[3], 1'b0, mem_base[3]};
                  enc.bytes[1] = mem_opc;
                  enc.bytes[2] = {mem_mod, mem_regf[2:0], mem_base[2:0]};
                  enc.bytes[3] = mem_disp[7:0];
                  enc.bytes[4] = mem_disp[15:8];
                  enc.bytes[5] = mem_disp[23:16];
                  enc.bytes[6] = mem_disp[31:24];
                  case (mem_mod)
                     2'd0:    enc.count = CNT_W'(3);
                     2'd1:    enc.count = CNT_W'(4);
                     default: enc.count = CNT_W'(7);
                  endcase
               end
            end else begin
               enc.err = ERR_TYPES;
            end
         end
         MODE_CALL: begin
            if (req.operand_count != 2'd1) begin
               enc.err = ERR_COUNT;
            end else if (req.first_kind != KIND_SYM) begin
               enc.err = ERR_TYPES;
            end else begin
               enc.bytes[0] = OP_CALL;
               enc.count    = CNT_W'(5);
               enc.is_call  = 1'b1;
            end
         end
         MODE_LEAVE, MODE_RET: begin
            if (req.operand_count != 2'd0) begin
               enc.err = ERR_COUNT;
            end else begin
               enc.bytes[0] = (req.mode == MODE_LEAVE) ? OP_LEAVE : OP_RET;
            end
         end
         default: begin
            enc.err = ERR_TYPES;
         end
      endcase
   end

   `ENC_ASSERT_SAME(a_err_single, valid && enc.err != ERR_NONE, enc.count == CNT_W'(1) && enc.bytes == '0, "error encoding must be one zero byte")
   `ENC_ASSERT_SAME(a_count_range, valid, enc.count != '0 && enc.count <= CNT_W'(MAX_BYTES), "encoded length out of range")
   `ENC_ASSERT_SAME(a_call_shape, valid && enc.is_call, enc.count == CNT_W'(5) && enc.err == ERR_NONE, "call must encode to five bytes")

endmodule
